[hdl/mmp_pkg.sv]
// shared types, constants and helpers of the modular matrix power unit
// used by modular_matrix_power_unit and mmp_div
package mmp_pkg;

  localparam int MAX_DIM    = 64;
  localparam int MOD_BITS   = 17;
  localparam int ELEM_W     = 31;
  localparam int DIM_BITS   = $clog2(MAX_DIM);
  localparam int SIZE_W     = $clog2(MAX_DIM + 1);
  localparam int CNT_W      = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int ADDR_W     = 2 * DIM_BITS;
  localparam int CELLS      = MAX_DIM * MAX_DIM;
  localparam int PROD_W     = 2 * MOD_BITS;
  localparam int XW_A       = (PROD_W > ELEM_W) ? PROD_W : ELEM_W;
  localparam int XW         = (XW_A > CNT_W) ? XW_A : CNT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PICK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COL_PICK = 3'd4;

  localparam logic [MOD_BITS-1:0] MODULUS_RST = MOD_BITS'(100007);

  // request to the shared divider
  typedef struct packed {
    logic                start;
    logic [XW-1:0]       num;
    logic [MOD_BITS-1:0] den;
  } div_req_t;

  // divider result, valid while done is high
  typedef struct packed {
    logic                done;
    logic [MOD_BITS-1:0] rem;
    logic [XW-1:0]       quo;
  } div_rsp_t;

  // store address of row r, column c with a fixed row stride
  function automatic logic [ADDR_W-1:0] mk_addr(logic [DIM_BITS-1:0] r,
                                                logic [DIM_BITS-1:0] c);
    return {r, c};
  endfunction

endpackage

[hdl/modular_matrix_power_unit.sv]
// top level: matrix load, square-and-multiply sequencer and result output
// depends on mmp_pkg, mmp_ram, mmp_div
//
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready         tdata[30:0] element, tlast last
//  m_axis    out  tvalid/tready         tdata[16:0] entry
//  cfg       in   cfg_valid_i/ready_o   cfg_index_i register, cfg_data_i value
//
// a load item within the n*n cells takes two passes of the shared divider
// (XW = 34), one for the row/column split and one for the element reduction;
// surplus items are dropped; the final item starts the identity setup of the
// accumulator, then one or two matrix products follow per exponent bit
// input ready is low while the sequencer is busy; a finished result waits in
// the output register while the next load proceeds
// reset clears control state only; the three matrix stores need no clearing
module modular_matrix_power_unit
  import mmp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // [30:0] element, [31] zero pad
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // [16:0] entry, [23:17] zero pad
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_LDDIV = 12'b0000_0000_0010,
    ST_LDRED = 12'b0000_0000_0100,
    ST_INIT  = 12'b0000_0000_1000,
    ST_EXP   = 12'b0000_0001_0000,
    ST_MRD   = 12'b0000_0010_0000,
    ST_MMUL  = 12'b0000_0100_0000,
    ST_MRED  = 12'b0000_1000_0000,
    ST_CPRD  = 12'b0001_0000_0000,
    ST_CPWR  = 12'b0010_0000_0000,
    ST_PKRD  = 12'b0100_0000_0000,
    ST_PKOUT = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [6:0]          size_q;
  logic [MOD_BITS-1:0] mod_q;
  logic [30:0]         exp_q;
  logic [6:0]          rpick_q;
  logic [6:0]          cpick_q;

  // sequencer registers
  logic [CNT_W-1:0]    count_q, count_d;
  logic [30:0]         shift_q, shift_d;
  logic                ph_q, ph_d;
  logic                sq_q, sq_d;
  logic [SIZE_W-1:0]   i_q, i_d, j_q, j_d, k_q, k_d;
  logic [MOD_BITS-1:0] acc_q, acc_d;
  logic [ELEM_W-1:0]   elem_q, elem_d;
  logic                last_q, last_d;
  logic [DIM_BITS-1:0] row_q, row_d, col_q, col_d;
  logic                out_valid_q, out_valid_d;
  logic [MOD_BITS-1:0] out_q, out_d;

  // derived operating values
  logic [7:0]          size_x;
  logic [SIZE_W-1:0]   n_eff, n_m1;
  logic [CNT_W-1:0]    total;
  logic [MOD_BITS-1:0] mod_eff, one_mod;
  logic [7:0]          rp_x, cp_x, n_x;
  logic                pick_ok;
  logic [6:0]          rp_m1, cp_m1;
  logic                in_acc, j_end, i_end;
  logic [MOD_BITS:0]   sum;

  // memories and divider
  logic                base_we, accum_we, scr_we;
  logic [ADDR_W-1:0]   base_wa, accum_wa, scr_wa;
  logic [MOD_BITS-1:0] base_wd, accum_wd, scr_wd;
  logic [ADDR_W-1:0]   addr_ik, addr_kj, addr_ij, pick_addr, accum_ra;
  logic [MOD_BITS-1:0] base_rd_a, base_rd_b, accum_rd_a, accum_rd_b, scr_rd, scr_rd_b;
  logic [MOD_BITS-1:0] op_a;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign size_x  = {1'b0, size_q};
  assign n_eff   = (size_x > 8'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : SIZE_W'(size_x);
  assign n_m1    = n_eff - SIZE_W'(1);
  assign total   = CNT_W'(n_eff) * CNT_W'(n_eff);
  assign mod_eff = (mod_q == '0) ? MOD_BITS'(1) : mod_q;
  assign one_mod = (mod_eff == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

  // result pick check
  assign rp_x    = {1'b0, rpick_q};
  assign cp_x    = {1'b0, cpick_q};
  assign n_x     = 8'(n_eff);
  assign pick_ok = (rp_x != 8'd0) && (rp_x <= n_x) && (cp_x != 8'd0) && (cp_x <= n_x);
  assign rp_m1   = rpick_q - 7'd1;
  assign cp_m1   = cpick_q - 7'd1;

  // address generation
  assign addr_ik   = mk_addr(i_q[DIM_BITS-1:0], k_q[DIM_BITS-1:0]);
  assign addr_kj   = mk_addr(k_q[DIM_BITS-1:0], j_q[DIM_BITS-1:0]);
  assign addr_ij   = mk_addr(i_q[DIM_BITS-1:0], j_q[DIM_BITS-1:0]);
  assign pick_addr = mk_addr(rp_m1[DIM_BITS-1:0], cp_m1[DIM_BITS-1:0]);
  assign accum_ra  = ((state_q == ST_PKRD) || (state_q == ST_PKOUT)) ? pick_addr : addr_ik;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign j_end  = (j_q == n_m1);
  assign i_end  = (i_q == n_m1);
  assign op_a   = sq_q ? base_rd_a : accum_rd_a;
  assign sum    = {1'b0, acc_q} + {1'b0, div_rsp.rem};

  // configuration writes
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= 7'd1;
      mod_q   <= MODULUS_RST;
      exp_q   <= '0;
      rpick_q <= 7'd1;
      cpick_q <= 7'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SIZE:     size_q  <= cfg_data_i[6:0];
        REG_MODULUS:  mod_q   <= cfg_data_i[MOD_BITS-1:0];
        REG_EXPONENT: exp_q   <= cfg_data_i[30:0];
        REG_ROW_PICK: rpick_q <= cfg_data_i[6:0];
        REG_COL_PICK: cpick_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    shift_d     = shift_q;
    ph_d        = ph_q;
    sq_d        = sq_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    acc_d       = acc_q;
    elem_d      = elem_q;
    last_d      = last_q;
    row_d       = row_q;
    col_d       = col_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    div_req     = '0;
    base_we     = 1'b0;
    base_wa     = addr_ij;
    base_wd     = scr_rd;
    accum_we    = 1'b0;
    accum_wa    = addr_ij;
    accum_wd    = scr_rd;
    scr_we      = 1'b0;
    scr_wa      = addr_ij;
    scr_wd      = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          elem_d = s_axis_tdata[ELEM_W-1:0];
          last_d = s_axis_tlast;
          if (count_q < total) begin
            div_req.start = 1'b1;
            div_req.num   = XW'(count_q);
            div_req.den   = MOD_BITS'(n_eff);
            state_d       = ST_LDDIV;
          end else begin
            count_d = total;
            if (s_axis_tlast) begin
              count_d = '0;
              i_d     = '0;
              j_d     = '0;
              state_d = (n_eff == '0) ? ST_PKRD : ST_INIT;
            end
          end
        end
      end
      ST_LDDIV: begin
        if (div_rsp.done) begin
          row_d         = div_rsp.quo[DIM_BITS-1:0];
          col_d         = div_rsp.rem[DIM_BITS-1:0];
          div_req.start = 1'b1;
          div_req.num   = XW'(elem_q);
          div_req.den   = mod_eff;
          state_d       = ST_LDRED;
        end
      end
      ST_LDRED: begin
        if (div_rsp.done) begin
          base_we = 1'b1;
          base_wa = mk_addr(row_q, col_q);
          base_wd = div_rsp.rem;
          count_d = count_q + CNT_W'(1);
          if (last_q) begin
            count_d = '0;
            i_d     = '0;
            j_d     = '0;
            state_d = ST_INIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      // accumulator starts as the identity
      ST_INIT: begin
        accum_we = 1'b1;
        accum_wd = (i_q == j_q) ? one_mod : '0;
        j_d      = j_q + SIZE_W'(1);
        if (j_end) begin
          j_d = '0;
          i_d = i_q + SIZE_W'(1);
          if (i_end) begin
            i_d     = '0;
            shift_d = exp_q;
            ph_d    = 1'b0;
            state_d = ST_EXP;
          end
        end
      end
      // pick the next product of square-and-multiply
      ST_EXP: begin
        i_d   = '0;
        j_d   = '0;
        k_d   = '0;
        acc_d = '0;
        if (shift_q == '0) begin
          state_d = ST_PKRD;
        end else begin
          sq_d    = !(shift_q[0] && !ph_q);
          state_d = ST_MRD;
        end
      end
      ST_MRD: begin
        state_d = ST_MMUL;
      end
      ST_MMUL: begin
        div_req.start = 1'b1;
        div_req.num   = XW'(PROD_W'(op_a) * PROD_W'(base_rd_b));
        div_req.den   = mod_eff;
        state_d       = ST_MRED;
      end
      // accumulate one reduced term
      ST_MRED: begin
        if (div_rsp.done) begin
          acc_d   = (sum >= {1'b0, mod_eff}) ? MOD_BITS'(sum - {1'b0, mod_eff})
                                             : sum[MOD_BITS-1:0];
          k_d     = k_q + SIZE_W'(1);
          state_d = ST_MRD;
          if (k_q == n_m1) begin
            scr_we = 1'b1;
            scr_wd = acc_d;
            acc_d  = '0;
            k_d    = '0;
            j_d    = j_q + SIZE_W'(1);
            if (j_end) begin
              j_d = '0;
              i_d = i_q + SIZE_W'(1);
              if (i_end) begin
                i_d     = '0;
                state_d = ST_CPRD;
              end
            end
          end
        end
      end
      ST_CPRD: begin
        state_d = ST_CPWR;
      end
      // copy the product back into its destination store
      ST_CPWR: begin
        base_we  = sq_q;
        accum_we = !sq_q;
        j_d      = j_q + SIZE_W'(1);
        state_d  = ST_CPRD;
        if (j_end) begin
          j_d = '0;
          i_d = i_q + SIZE_W'(1);
          if (i_end) begin
            i_d     = '0;
            state_d = ST_EXP;
            if (sq_q) begin
              shift_d = shift_q >> 1;
              ph_d    = 1'b0;
            end else begin
              ph_d = 1'b1;
            end
          end
        end
      end
      ST_PKRD: begin
        state_d = ST_PKOUT;
      end
      ST_PKOUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_d       = pick_ok ? accum_rd_a : '0;
          count_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      shift_q     <= '0;
      ph_q        <= 1'b0;
      sq_q        <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      shift_q     <= shift_d;
      ph_q        <= ph_d;
      sq_q        <= sq_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    elem_q <= elem_d;
    row_q  <= row_d;
    col_q  <= col_d;
    out_q  <= out_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 24'(out_q);

  // matrix stores
  mmp_ram #(.W(MOD_BITS), .D(CELLS)) u_base_ram (
    .clk_i     (clk_i),
    .we_i      (base_we),
    .waddr_i   (base_wa),
    .wdata_i   (base_wd),
    .raddr_a_i (addr_ik),
    .raddr_b_i (addr_kj),
    .rdata_a_o (base_rd_a),
    .rdata_b_o (base_rd_b)
  );

  mmp_ram #(.W(MOD_BITS), .D(CELLS)) u_accum_ram (
    .clk_i     (clk_i),
    .we_i      (accum_we),
    .waddr_i   (accum_wa),
    .wdata_i   (accum_wd),
    .raddr_a_i (accum_ra),
    .raddr_b_i (accum_ra),
    .rdata_a_o (accum_rd_a),
    .rdata_b_o (accum_rd_b)
  );

  mmp_ram #(.W(MOD_BITS), .D(CELLS)) u_scratch_ram (
    .clk_i     (clk_i),
    .we_i      (scr_we),
    .waddr_i   (scr_wa),
    .wdata_i   (scr_wd),
    .raddr_a_i (addr_ij),
    .raddr_b_i (addr_ij),
    .rdata_a_o (scr_rd),
    .rdata_b_o (scr_rd_b)
  );

  // shared divider
  mmp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // divider results arrive only where the sequencer waits for them
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_LDDIV) || (state_q == ST_LDRED) ||
                     (state_q == ST_MRED))
    else $error("unexpected divider result");

  // a product entry is written only after its last term
  a_scr_write_last_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scr_we |-> (k_q == n_m1) && (i_q < n_eff) && (j_q < n_eff))
    else $error("scratch write before the sum is complete");

  // both read ports of the single accumulator store address the picked entry and agree
  a_accum_ports_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PKOUT) |-> (accum_rd_a == accum_rd_b))
    else $error("accumulator read ports disagree");

  // both scratch read ports see the same product entry during the copy
  a_scr_ports_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CPWR) |-> (scr_rd == scr_rd_b))
    else $error("scratch read ports disagree");

endmodule

[hdl/mmp_ram.sv]
// generic single-write, dual-read RAM with registered read data
// no dependencies
module mmp_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_a_i,
  input  logic [$clog2(D)-1:0] raddr_b_i,
  output logic [W-1:0]         rdata_a_o,
  output logic [W-1:0]         rdata_b_o
);

  logic [W-1:0] mem_q [D];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[hdl/mmp_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on mmp_pkg
module mmp_div
  import mmp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int STEP_W = $clog2(XW + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic [XW-1:0]       num_q, num_d;
  logic [MOD_BITS-1:0] rem_q, rem_d;
  logic [MOD_BITS-1:0] den_q, den_d;
  logic [MOD_BITS:0]   trial;
  logic [MOD_BITS:0]   diff;
  logic                ge;

  // one restoring step
  assign trial = {rem_q, num_q[XW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(XW);
      num_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      num_d = {num_q[XW-2:0], ge};
      rem_d = ge ? diff[MOD_BITS-1:0] : trial[MOD_BITS-1:0];
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;
  assign rsp_o.quo  = num_q;

  // a new request never lands on a running division
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider restarted while busy");

  // a finished division has run all its steps
  a_done_after_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (cnt_q == '0) && !busy_q)
    else $error("divider done early");

  // a zero divisor never reaches the divider
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (req_i.den != '0))
    else $error("divide by zero requested");

endmodule
